[sv/utf16_to_utf8_encoder_unit_assert.svh]
// Assertion macros for the UTF-16 to UTF-8 encoder unit.
`ifndef UTF16_TO_UTF8_ENCODER_UNIT_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define U16U8_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`define U16U8_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define U16U8_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define U16U8_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

[sv/u16u8_pkg.sv]
// Types and constants shared by the UTF-16 to UTF-8 encoder modules.
`default_nettype none
package u16u8_pkg;
	localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
	localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
	localparam logic [15:0] SURR_HI_MIN  = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX  = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN  = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX  = 16'hDFFF;
	localparam logic [10:0] PLANE_OFFSET = 11'd64;
	localparam logic [7:0]  ERR_BYTE     = 8'h3F;
	localparam logic [7:0]  CONT_MARK    = 8'h80;
	localparam logic [7:0]  LEAD2        = 8'hC0;
	localparam logic [7:0]  LEAD3        = 8'hE0;
	localparam logic [7:0]  LEAD4        = 8'hF0;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} seq_t;

	typedef struct packed {
		logic valid;
		seq_t seq;
	} seq_wr_t;

	typedef struct packed {
		logic empty;
		seq_t seq;
	} seq_rd_t;
endpackage
`default_nettype wire

[sv/u16u8_front.sv]
// Front end: accepts code units, tracks the held surrogate and builds byte sequences.
`default_nettype none
module u16u8_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [15:0]       code_unit,
	input  wire logic              final_unit,
	output logic                   full,
	input  wire logic              wr_ready,
	output u16u8_pkg::seq_wr_t     wr,
	output logic                   pending
);
	logic            pending_q;
	logic [9:0]      hi_bits_q;
	logic            is_hi;
	logic            is_lo;
	logic            pair;
	logic            accept;
	logic [2:0][7:0] f;
	logic [1:0]      fcnt;
	logic [10:0]     upper;
	logic [20:0]     cp;

	always_comb begin
		is_hi = (code_unit >= u16u8_pkg::SURR_HI_MIN) && (code_unit <= u16u8_pkg::SURR_HI_MAX);
		is_lo = (code_unit >= u16u8_pkg::SURR_LO_MIN) && (code_unit <= u16u8_pkg::SURR_LO_MAX);
		f     = '0;
		priority if (code_unit <= u16u8_pkg::ONE_BYTE_MAX) begin
			f[0] = code_unit[7:0];
			fcnt = 2'd1;
		end else if (code_unit <= u16u8_pkg::TWO_BYTE_MAX) begin
			f[0] = u16u8_pkg::LEAD2 | {3'b000, code_unit[10:6]};
			f[1] = u16u8_pkg::CONT_MARK | {2'b00, code_unit[5:0]};
			fcnt = 2'd2;
		end else if (is_hi) begin
			fcnt = 2'd0;
		end else if (is_lo) begin
			f[0] = u16u8_pkg::ERR_BYTE;
			fcnt = 2'd1;
		end else begin
			f[0] = u16u8_pkg::LEAD3 | {4'b0000, code_unit[15:12]};
			f[1] = u16u8_pkg::CONT_MARK | {2'b00, code_unit[11:6]};
			f[2] = u16u8_pkg::CONT_MARK | {2'b00, code_unit[5:0]};
			fcnt = 2'd3;
		end

		upper = {1'b0, hi_bits_q} + u16u8_pkg::PLANE_OFFSET;
		cp    = {upper[10:0], code_unit[9:0]};
		pair  = pending_q && is_lo;

		wr.seq = '0;
		priority if (pair) begin
			wr.seq.bytes[0] = u16u8_pkg::LEAD4 | {5'b00000, cp[20:18]};
			wr.seq.bytes[1] = u16u8_pkg::CONT_MARK | {2'b00, cp[17:12]};
			wr.seq.bytes[2] = u16u8_pkg::CONT_MARK | {2'b00, cp[11:6]};
			wr.seq.bytes[3] = u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
			wr.seq.last_idx = 2'd3;
		end else if (pending_q) begin
			wr.seq.bytes[0]   = u16u8_pkg::ERR_BYTE;
			wr.seq.bytes[3:1] = f;
			wr.seq.last_idx   = fcnt;
		end else begin
			wr.seq.bytes[2:0] = f;
			wr.seq.last_idx   = fcnt - 2'd1;
		end

		accept   = push && wr_ready;
		wr.valid = accept && (pending_q || (fcnt != 2'd0));
	end

	assign full    = !wr_ready;
	assign pending = pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= is_hi && !final_unit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_hi) begin
			hi_bits_q <= code_unit[9:0];
		end
	end
endmodule
`default_nettype wire

[sv/u16u8_fifo.sv]
// Short queue of byte sequences between the front end and the byte serializer.
`default_nettype none
module u16u8_fifo #(
	parameter int Depth = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u16u8_pkg::seq_wr_t wr,
	output logic                    wr_ready,
	output u16u8_pkg::seq_rd_t      rd,
	input  wire logic               rd_pop
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	u16u8_pkg::seq_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_ready = (cnt_q != FullCnt);
	assign rd.empty = (cnt_q == '0);
	assign rd.seq   = mem_q[rd_ptr_q];
	assign do_wr    = wr.valid && wr_ready;
	assign do_rd    = rd_pop && !rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.seq;
		end
	end
endmodule
`default_nettype wire

[sv/u16u8_back.sv]
// Back end: sends the bytes of each queued sequence one at a time through an output register.
`default_nettype none
module u16u8_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u16u8_pkg::seq_rd_t rd,
	output logic                    rd_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic [7:0]              out_byte,
	output logic                    run_last
);
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load     = !rd.empty && (!out_valid_q || pop);
	assign at_last  = (idx_q == rd.seq.last_idx);
	assign rd_pop   = load && at_last;
	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= rd.seq.bytes[idx_q];
			run_last_q <= at_last;
		end
	end
endmodule
`default_nettype wire

[sv/utf16_to_utf8_encoder_unit.sv]
// Top level of the UTF-16 to UTF-8 encoder unit.
// Usage:
// The input side is a queue write port: an item (code_unit, final_unit) is taken at a
// rising edge with push high and full low. The result side is a queue read port: while
// empty is low, out_byte and run_last show the oldest byte, which is taken at an edge
// with pop high. run_last marks the last byte caused by one item.
// Each item yields zero to four bytes. A high surrogate yields none and is held until
// the next item; final_unit drops a held surrogate once its item is handled.
// The front end decodes an item in its accept cycle and writes its whole byte sequence
// into a queue of QueueDepth entries; the back end sends one byte per cycle when not stalled.
// The first byte of an item passes through the queue and then the output register.
// The single output register holds the byte shown; the front end can take a new item
// while bytes of earlier items are still being sent, as long as the queue has room.
// When the receiver stalls, the output byte holds, the queue fills, and full rises.
// Reset clears the held surrogate, the queue and the output register.
`default_nettype none
`include "utf16_to_utf8_encoder_unit_assert.svh"
module utf16_to_utf8_encoder_unit #(
	parameter int QueueDepth = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] code_unit,
	input  wire logic        final_unit,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             run_last
);
	u16u8_pkg::seq_wr_t q_wr;
	u16u8_pkg::seq_rd_t q_rd;
	logic               q_wr_ready;
	logic               q_pop;
	logic               pending;
	logic               in_accept;
	logic               in_hi;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.full       (full),
		.wr_ready   (q_wr_ready),
		.wr         (q_wr),
		.pending    (pending)
	);

	u16u8_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_ready (q_wr_ready),
		.rd       (q_rd),
		.rd_pop   (q_pop)
	);

	u16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (q_rd),
		.rd_pop   (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	assign in_accept = push && !full;
	assign in_hi     = (code_unit >= u16u8_pkg::SURR_HI_MIN) &&
		(code_unit <= u16u8_pkg::SURR_HI_MAX);

	`U16U8_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, q_wr.valid, q_wr_ready)
	`U16U8_ASSERT_IMPLIES(a_no_underflow, clk, arst_n, q_pop, !q_rd.empty)
	`U16U8_ASSERT_NEXT(a_final_clears, clk, arst_n, in_accept && final_unit, !pending)
	`U16U8_ASSERT_NEXT(a_high_held, clk, arst_n, in_accept && !final_unit && in_hi, pending)
endmodule
`default_nettype wire
